// File: src/ssm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssm_pkg;

	localparam int VAL_W       = 32;
	localparam int OP_W        = 2;
	localparam int MAX_RESULTS = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
	localparam logic [OP_W-1:0] OP_MERGE  = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]  kind;
		logic [VAL_W-1:0] value;
	} cmd_t;

endpackage
`default_nettype wire

// File: src/ssm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ssm_front (
	input  wire                       s_tvalid,
	output logic                      s_tready,
	input  wire  [ssm_pkg::VAL_W-1:0] s_tdata,
	input  wire  [ssm_pkg::OP_W-1:0]  s_tuser,
	output logic                      push_valid,
	input  wire                       push_ready,
	output ssm_pkg::cmd_t             push_cmd
);
	import ssm_pkg::*;

	// unused opcode is swallowed here and never reaches the queue
	assign s_tready       = push_ready;
	assign push_valid     = s_tvalid && (s_tuser != OP_UNUSED);
	assign push_cmd.kind  = s_tuser;
	assign push_cmd.value = s_tdata;

endmodule
`default_nettype wire

// File: src/ssm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module ssm_queue (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  ssm_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  wire           out_ready,
	output ssm_pkg::cmd_t out_cmd
);
	import ssm_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign in_ready  = cnt_q != CW'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_cmd   = entry_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

endmodule
`default_nettype wire

// File: src/ssm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ssm_back #(
	parameter int DEPTH = 16
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cmd_valid,
	output logic                      cmd_ready,
	input  ssm_pkg::cmd_t             cmd,
	output logic                      m_tvalid,
	input  wire                       m_tready,
	output logic [ssm_pkg::VAL_W-1:0] m_tdata,
	output logic [1:0]                m_tuser,
	output logic                      m_tlast
);
	import ssm_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int TW = $clog2(2 * DEPTH + MAX_RESULTS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_MERGE = 2'd2;

	logic [VAL_W-1:0] mem_a [DEPTH];
	logic [VAL_W-1:0] mem_b [DEPTH];

	logic [1:0]       state_q;
	logic [CW-1:0]    cnt_a_q, cnt_b_q, ia_q, ib_q, ia_d, ib_d;
	logic [TW-1:0]    k_q, sum, total;
	logic             drop_q;
	logic [VAL_W-1:0] rd_a_q, rd_b_q;
	logic             out_valid_q, out_empty_q, out_ovf_q, out_last_q;
	logic [VAL_W-1:0] out_data_q;

	logic pop, wr_a, wr_b, full_a, full_b;
	logic can_emit, have_a, have_b, take_a, emit_merge, last_m, emit_empty;

	assign cmd_ready = state_q == ST_IDLE;
	assign pop       = cmd_valid && cmd_ready;
	assign full_a    = cnt_a_q == CW'(DEPTH);
	assign full_b    = cnt_b_q == CW'(DEPTH);
	assign wr_a      = pop && (cmd.kind == OP_LOAD_A) && !full_a;
	assign wr_b      = pop && (cmd.kind == OP_LOAD_B) && !full_b;

	assign sum      = TW'(cnt_a_q) + TW'(cnt_b_q);
	assign total    = (sum > TW'(MAX_RESULTS)) ? TW'(MAX_RESULTS) : sum;
	assign can_emit = !out_valid_q || m_tready;
	assign have_a   = ia_q < cnt_a_q;
	assign have_b   = ib_q < cnt_b_q;
	assign take_a   = have_a && (!have_b || ($signed(rd_a_q) <= $signed(rd_b_q)));
	assign emit_merge = (state_q == ST_MERGE) && can_emit;
	assign emit_empty = (state_q == ST_START) && (total == '0) && can_emit;
	assign last_m     = (k_q + 1'b1) == total;

	// read address runs one step ahead so rd_*_q always holds the current head
	always_comb begin
		ia_d = '0;
		ib_d = '0;
		if (state_q == ST_MERGE) begin
			ia_d = ia_q + CW'(emit_merge && take_a);
			ib_d = ib_q + CW'(emit_merge && !take_a);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[cnt_a_q[AW-1:0]] <= cmd.value;
		end
		rd_a_q <= mem_a[ia_d[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[cnt_b_q[AW-1:0]] <= cmd.value;
		end
		rd_b_q <= mem_b[ib_d[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (emit_merge) begin
			out_data_q  <= take_a ? rd_a_q : rd_b_q;
			out_empty_q <= 1'b0;
			out_ovf_q   <= drop_q;
			out_last_q  <= last_m;
		end else if (emit_empty) begin
			out_data_q  <= '0;
			out_empty_q <= 1'b1;
			out_ovf_q   <= drop_q;
			out_last_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			drop_q      <= 1'b0;
			ia_q        <= '0;
			ib_q        <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ia_q <= ia_d;
			ib_q <= ib_d;
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_merge || emit_empty) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (pop) begin
						if (wr_a) begin
							cnt_a_q <= cnt_a_q + 1'b1;
						end
						if (wr_b) begin
							cnt_b_q <= cnt_b_q + 1'b1;
						end
						if ((cmd.kind == OP_LOAD_A && full_a) ||
							(cmd.kind == OP_LOAD_B && full_b)) begin
							drop_q <= 1'b1;
						end
						if (cmd.kind == OP_MERGE) begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					if (total != '0) begin
						state_q <= ST_MERGE;
					end else if (emit_empty) begin
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_MERGE: begin
					if (emit_merge) begin
						k_q <= k_q + 1'b1;
						if (last_m) begin
							cnt_a_q <= '0;
							cnt_b_q <= '0;
							drop_q  <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = {out_ovf_q, out_empty_q};
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

// File: src/sorted_sequence_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | tdata            | tuser                       | tlast
// s_*     | in  | [31:0] value     | [1:0] operation             | -
// m_*     | out | [31:0] merged    | [0] empty_res, [1] overflow | last
//
// The back end takes a load whenever it is idle; a 2-entry command queue lets the
// input accept up to two commands while a merge runs. A merge passes a setup state,
// then one result per cycle while m_tready allows it; an empty merge sends its lone
// beat from the setup state. Pacing comes from the registered store read ports
// and the output register. arst_n clears counts and flags;
// the stores need no clearing. m_tready low holds the result and stalls the merge.
module sorted_sequence_merge #(
	parameter int DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] value
	input  wire  [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [31:0] merged_value
	output logic [1:0]  m_tuser,   // [0] empty_res, [1] overflow
	output logic        m_tlast
);
	import ssm_pkg::*;

	logic push_valid, push_ready, cmd_valid, cmd_ready;
	cmd_t push_cmd, cmd;

	ssm_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	ssm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push_valid),
		.in_ready (push_ready),
		.in_cmd   (push_cmd),
		.out_valid(cmd_valid),
		.out_ready(cmd_ready),
		.out_cmd  (cmd)
	);

	ssm_back #(.DEPTH(DEPTH)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// File: src/ssm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ssm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [31:0] s_tdata,
	input wire [1:0]  s_tuser,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [31:0] m_tdata,
	input wire [1:0]  m_tuser,
	input wire        m_tlast
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("input beat changed while stalled");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_empty_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 32'd0))
		else $error("empty result not a lone zero beat");

	a_merge_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && !m_tuser[0])
		else $error("gap inside a merge burst");

endmodule

bind sorted_sequence_merge ssm_checker u_chk (.*);
`default_nettype wire
